@@ src/spat_pkg.sv @@
// ============================================================================
// spat_pkg
// Types and constants shared by the segmented page address translator.
// ============================================================================
`default_nettype none

package spat_pkg;

   // Address layout of a virtual address.
   localparam int SEG_LSB   = 22;
   localparam int PAGE_LSB  = 12;
   localparam int NUM_W     = 10;
   localparam int OFFSET_W  = 12;
   localparam int FRAME_W   = 20;

   // Field widths of the request channel.
   localparam int SEG_INDEX_W  = 4;
   localparam int PAGE_INDEX_W = 6;
   localparam int PAGE_COUNT_W = 7;

   // Writable index ranges follow from the field widths above.
   localparam int SEG_TABLE_LIMIT  = 16;
   localparam int PAGE_INDEX_LIMIT = 64;
   localparam int PAGE_COUNT_LIMIT = 127;

   // Widest page entry address (16 segments of 64 pages).
   localparam int ENTRY_ADDR_W = 10;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_TRANSLATE = 2'd0,
      OP_SET_COUNT = 2'd1,
      OP_SET_ENTRY = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_SEGMENT = 2'd1,
      STATUS_NO_PAGE    = 2'd2,
      STATUS_NOT_LOADED = 2'd3
   } status_type;

   // What the back end does with a queued word.
   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_LOOKUP = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      BACK_CLEAR = 2'b01,
      BACK_RUN   = 2'b10
   } back_state_type;

   typedef struct packed {
      kind_type                 kind;
      logic [ENTRY_ADDR_W-1:0]  addr;
      logic [FRAME_W-1:0]       frame;
      logic                     loaded;
      logic [OFFSET_W-1:0]      offset;
      status_type               status;
      logic [NUM_W-1:0]         fault;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

`default_nettype wire

@@ src/spat_req_if.sv @@
// ============================================================================
// spat_req_if
// Request channel: translate and table load words with valid/ready.
// ============================================================================
`default_nettype none

interface spat_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] virtual_address;
   logic [3:0]  segment_index;
   logic [5:0]  page_index;
   logic [6:0]  page_count;
   logic [19:0] page_frame;
   logic        page_loaded;

   modport source (
      output valid, operation, virtual_address, segment_index, page_index,
             page_count, page_frame, page_loaded,
      input  ready
   );

   modport sink (
      input  valid, operation, virtual_address, segment_index, page_index,
             page_count, page_frame, page_loaded,
      output ready
   );
endinterface

`default_nettype wire

@@ src/spat_rsp_if.sv @@
// ============================================================================
// spat_rsp_if
// Response channel: translation results with valid/ready.
// ============================================================================
`default_nettype none

interface spat_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] physical_address;
   logic [9:0]  fault_number;

   modport source (
      output valid, status, physical_address, fault_number,
      input  ready
   );

   modport sink (
      input  valid, status, physical_address, fault_number,
      output ready
   );
endinterface

`default_nettype wire

@@ src/spat_ram.sv @@
// ============================================================================
// spat_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
`default_nettype none

module spat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic                                   re,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ src/spat_front.sv @@
// ============================================================================
// spat_front
// Accepts request words, keeps the segment count and page count tables and
// classifies translations before they are queued for the back end.
// ============================================================================
`default_nettype none

module spat_front #(
   parameter int MAX_SEGMENTS = 16,
   parameter int MAX_PAGES    = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [4:0]                csr_write_data,
   spat_req_if.sink                       req,
   input  wire logic                      back_busy,
   input  wire spat_pkg::queue_status_type q_status,
   output logic                           push,
   output spat_pkg::queue_entry_type      entry
);

   localparam int SEG_D = (MAX_SEGMENTS < spat_pkg::SEG_TABLE_LIMIT) ?
                          MAX_SEGMENTS : spat_pkg::SEG_TABLE_LIMIT;
   localparam int PG_D  = (MAX_PAGES < spat_pkg::PAGE_INDEX_LIMIT) ?
                          MAX_PAGES : spat_pkg::PAGE_INDEX_LIMIT;
   localparam int SEG_W = (SEG_D > 1) ? $clog2(SEG_D) : 1;
   localparam int PG_W  = (PG_D > 1) ? $clog2(PG_D) : 1;
   localparam int CNT_MAX = (MAX_PAGES < spat_pkg::PAGE_COUNT_LIMIT) ?
                            MAX_PAGES : spat_pkg::PAGE_COUNT_LIMIT;
   localparam int CNT_W = $clog2(CNT_MAX + 1);

   logic [4:0]       seg_count_ff;
   logic [4:0]       seg_count_in;
   logic [CNT_W-1:0] count_ff [SEG_D];
   logic [CNT_W-1:0] count_in [SEG_D];

   logic                         accept;
   logic [spat_pkg::NUM_W-1:0]   seg;
   logic [spat_pkg::NUM_W-1:0]   page;
   logic [SEG_W-1:0]             seg_lo;
   logic [PG_W-1:0]              page_lo;
   logic [SEG_W-1:0]             si_lo;
   logic [PG_W-1:0]              pi_lo;
   logic                         seg_present;
   logic                         seg_in_table;
   logic [CNT_W-1:0]             count_sel;
   logic                         page_ok;
   logic                         page_in_mem;
   logic                         si_ok;
   logic                         pi_ok;
   logic [CNT_W-1:0]             count_sat;

   assign req.ready = q_status.full == 1'b0 && !back_busy;
   assign accept    = req.valid && req.ready;

   assign seg     = req.virtual_address[spat_pkg::SEG_LSB +: spat_pkg::NUM_W];
   assign page    = req.virtual_address[spat_pkg::PAGE_LSB +: spat_pkg::NUM_W];
   assign seg_lo  = seg[SEG_W-1:0];
   assign page_lo = page[PG_W-1:0];
   assign si_lo   = req.segment_index[SEG_W-1:0];
   assign pi_lo   = req.page_index[PG_W-1:0];

   // A segment exists below both the configured count and the parameter.
   assign seg_present  = (seg < {5'd0, seg_count_ff}) &&
                         ({1'b0, seg} < 11'(MAX_SEGMENTS));
   assign seg_in_table = seg < 10'(SEG_D);
   assign count_sel    = seg_in_table ? count_ff[seg_lo] : '0;
   assign page_ok      = page < 10'(count_sel);
   // Pages beyond the writable range are never loaded.
   assign page_in_mem  = page < 10'(PG_D);

   assign si_ok = {1'b0, req.segment_index} < 5'(SEG_D);
   assign pi_ok = {1'b0, req.page_index} < 7'(PG_D);
   assign count_sat = (int'(req.page_count) > MAX_PAGES) ?
                      CNT_W'(MAX_PAGES) : CNT_W'(req.page_count);

   assign seg_count_in = csr_write_enable ? csr_write_data : seg_count_ff;

   always_comb begin
      count_in = count_ff;
      push     = 1'b0;
      entry    = '0;
      entry.offset = req.virtual_address[spat_pkg::OFFSET_W-1:0];
      unique case (req.operation)
         spat_pkg::OP_SET_COUNT: begin
            if (accept && si_ok) begin
               count_in[si_lo] = count_sat;
            end
         end
         spat_pkg::OP_SET_ENTRY: begin
            push         = accept && si_ok && pi_ok;
            entry.kind   = spat_pkg::KIND_WRITE;
            entry.addr   = spat_pkg::ENTRY_ADDR_W'(int'(si_lo) * PG_D + int'(pi_lo));
            entry.frame  = req.page_frame;
            entry.loaded = req.page_loaded;
         end
         spat_pkg::OP_TRANSLATE: begin
            push       = accept;
            entry.addr = spat_pkg::ENTRY_ADDR_W'(int'(seg_lo) * PG_D + int'(page_lo));
            if (!seg_present) begin
               entry.kind   = spat_pkg::KIND_ERROR;
               entry.status = spat_pkg::STATUS_NO_SEGMENT;
               entry.fault  = seg;
            end else if (!page_ok) begin
               entry.kind   = spat_pkg::KIND_ERROR;
               entry.status = spat_pkg::STATUS_NO_PAGE;
               entry.fault  = page;
            end else if (!page_in_mem) begin
               entry.kind   = spat_pkg::KIND_ERROR;
               entry.status = spat_pkg::STATUS_NOT_LOADED;
               entry.fault  = page;
            end else begin
               entry.kind   = spat_pkg::KIND_LOOKUP;
               entry.status = spat_pkg::STATUS_OK;
               entry.fault  = page;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= '0;
         count_ff     <= '{default: '0};
      end else begin
         seg_count_ff <= seg_count_in;
         count_ff     <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ src/spat_queue.sv @@
// ============================================================================
// spat_queue
// Two-word queue between the front end and the back end.
// ============================================================================
`default_nettype none

module spat_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire spat_pkg::queue_entry_type  push_entry,
   input  wire logic                       pop,
   output spat_pkg::queue_entry_type       head,
   output spat_pkg::queue_status_type      status
);

   localparam int PTR_W = $clog2(spat_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(spat_pkg::QUEUE_DEPTH + 1);

   spat_pkg::queue_entry_type slot_ff [spat_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign head             = slot_ff[rd_ptr_ff];
   assign status.full      = count_ff == CNT_W'(spat_pkg::QUEUE_DEPTH);
   assign status.not_empty = count_ff != '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(spat_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(spat_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ src/spat_back.sv @@
// ============================================================================
// spat_back
// Page entry RAM with its clearing pass, the lookup stage and the response
// output register.
// ============================================================================
`default_nettype none

module spat_back #(
   parameter int MAX_SEGMENTS = 16,
   parameter int MAX_PAGES    = 64,
   parameter int FRAME_BITS   = 20
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire spat_pkg::queue_entry_type  head,
   input  wire spat_pkg::queue_status_type q_status,
   output logic                            pop,
   output logic                            busy,
   spat_rsp_if.source                      rsp
);

   localparam int SEG_D = (MAX_SEGMENTS < spat_pkg::SEG_TABLE_LIMIT) ?
                          MAX_SEGMENTS : spat_pkg::SEG_TABLE_LIMIT;
   localparam int PG_D  = (MAX_PAGES < spat_pkg::PAGE_INDEX_LIMIT) ?
                          MAX_PAGES : spat_pkg::PAGE_INDEX_LIMIT;
   localparam int MEM_D  = SEG_D * PG_D;
   localparam int ADDR_W = (MEM_D > 1) ? $clog2(MEM_D) : 1;
   localparam int WORD_W = FRAME_BITS + 1;

   spat_pkg::back_state_type state_ff;
   spat_pkg::back_state_type state_in;
   logic [ADDR_W-1:0]        clr_ff;
   logic [ADDR_W-1:0]        clr_in;

   logic                      stage_valid_ff;
   logic                      stage_valid_in;
   spat_pkg::queue_entry_type stage_ff;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   spat_pkg::status_type               rsp_status_ff;
   spat_pkg::status_type               rsp_status_in;
   logic [31:0]                        rsp_pa_ff;
   logic [31:0]                        rsp_pa_in;
   logic [spat_pkg::NUM_W-1:0]         rsp_fault_ff;
   logic [spat_pkg::NUM_W-1:0]         rsp_fault_in;

   logic              clearing;
   logic              out_free;
   logic              stage_move;
   logic              stage_free;
   logic              head_write;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic              ram_re;
   logic [WORD_W-1:0] ram_rdata;
   logic              hit_loaded;

   assign clearing   = state_ff == spat_pkg::BACK_CLEAR;
   assign busy       = clearing;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign stage_move = stage_valid_ff && out_free;
   assign stage_free = !stage_valid_ff || stage_move;
   assign head_write = head.kind == spat_pkg::KIND_WRITE;

   // Table writes bypass the lookup stage; results need a free stage.
   assign pop = !clearing && q_status.not_empty && (head_write || stage_free);

   assign ram_we    = clearing || (pop && head_write);
   assign ram_waddr = clearing ? clr_ff : head.addr[ADDR_W-1:0];
   assign ram_wdata = clearing ? '0 : {head.loaded, head.frame[FRAME_BITS-1:0]};
   assign ram_re    = pop && head.kind == spat_pkg::KIND_LOOKUP;

   spat_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_D)
   ) u_entries (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (head.addr[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   assign hit_loaded = ram_rdata[FRAME_BITS];

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         spat_pkg::BACK_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(MEM_D - 1)) begin
               state_in = spat_pkg::BACK_RUN;
            end
         end
         spat_pkg::BACK_RUN: begin
         end
         default: begin
            state_in = spat_pkg::BACK_CLEAR;
         end
      endcase
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (pop && !head_write) begin
         stage_valid_in = 1'b1;
      end else if (stage_move) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pa_in     = rsp_pa_ff;
      rsp_fault_in  = rsp_fault_ff;
      if (stage_move) begin
         rsp_valid_in = 1'b1;
         if (stage_ff.kind == spat_pkg::KIND_LOOKUP && hit_loaded) begin
            rsp_status_in = spat_pkg::STATUS_OK;
            rsp_pa_in     = {spat_pkg::FRAME_W'(ram_rdata[FRAME_BITS-1:0]),
                             stage_ff.offset};
            rsp_fault_in  = '0;
         end else if (stage_ff.kind == spat_pkg::KIND_LOOKUP) begin
            rsp_status_in = spat_pkg::STATUS_NOT_LOADED;
            rsp_pa_in     = '0;
            rsp_fault_in  = stage_ff.fault;
         end else begin
            rsp_status_in = stage_ff.status;
            rsp_pa_in     = '0;
            rsp_fault_in  = stage_ff.fault;
         end
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && !head_write) begin
         stage_ff <= head;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_pa_ff     <= rsp_pa_in;
      rsp_fault_ff  <= rsp_fault_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= spat_pkg::BACK_CLEAR;
         clr_ff         <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.status           = rsp_status_ff;
   assign rsp.physical_address = rsp_pa_ff;
   assign rsp.fault_number     = rsp_fault_ff;

endmodule

`default_nettype wire

@@ src/segmented_page_address_translator_unit.sv @@
// ============================================================================
// segmented_page_address_translator_unit
// Segmented paging translation: segment and page range checks, page entry
// lookup, and loads of the page count and page entry tables.
// ============================================================================
//
//   Channel  Direction  Handshake            Word
//   req_if   in         valid/ready          operation, address, table load data
//   rsp_if   out        valid/ready          status, physical address, fault number
//   csr_*    in         write enable, no ack segment count
//
// A translation or load is accepted every cycle while the response side keeps up.
// A translation result passes through the queue write, the entry RAM read and the
// response register. After reset the entry RAM of MAX_SEGMENTS*MAX_PAGES entries
// (capped at 16 by 64, so 1024 by default) is cleared with req_if.ready low.
// When rsp_if stalls, the two-word queue and the lookup stage absorb words
// before req_if.ready drops.
//
`default_nettype none

module segmented_page_address_translator_unit #(
   parameter int MAX_SEGMENTS = 16,
   parameter int MAX_PAGES    = 64,
   parameter int FRAME_BITS   = 20
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [4:0] csr_write_data,
   spat_req_if.sink        req_if,
   spat_rsp_if.source      rsp_if
);

   logic                       push;
   logic                       pop;
   logic                       back_busy;
   spat_pkg::queue_entry_type  push_entry;
   spat_pkg::queue_entry_type  head;
   spat_pkg::queue_status_type q_status;

   spat_front #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .MAX_PAGES    (MAX_PAGES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_if),
      .back_busy        (back_busy),
      .q_status         (q_status),
      .push             (push),
      .entry            (push_entry)
   );

   spat_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   spat_back #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .MAX_PAGES    (MAX_PAGES),
      .FRAME_BITS   (FRAME_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .busy     (back_busy),
      .rsp      (rsp_if)
   );

endmodule

`default_nettype wire
